FILE: src/cave_automaton_row_step_assert.svh
// Assertion macros used by the port-level checks of the cave automaton row step.
`ifndef CAVE_AUTOMATON_ROW_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_ROW_STEP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CARS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also holds while reset is applied.
`define CARS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cars_pkg.sv
// Types and constants of the cave automaton row step.
package cars_pkg;

  localparam int ROW_BITS   = 64;
  localparam int WIDTH_BITS = 7;
  localparam int LIMIT_BITS = 4;
  localparam int COUNT_BITS = 4;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RST      = 7'd64;
  localparam logic [LIMIT_BITS-1:0] STARVATION_RST     = 4'd3;
  localparam logic [LIMIT_BITS-1:0] OVERPOPULATION_RST = 4'd10;
  localparam logic [LIMIT_BITS-1:0] BIRTH_RST          = 4'd4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROW_WIDTH      = 2'd0;
  localparam logic [1:0] REG_STARVATION     = 2'd1;
  localparam logic [1:0] REG_OVERPOPULATION = 2'd2;
  localparam logic [1:0] REG_BIRTH          = 2'd3;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] starvation;
    logic [LIMIT_BITS-1:0] overpopulation;
    logic [LIMIT_BITS-1:0] birth;
  } rule_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_cells;
    logic                frame_done;
  } result_t;

endpackage

FILE: src/cars_if.sv
// Valid/ready channels for input rows and result rows.
interface cars_in_if;
  logic                         valid;
  logic                         ready;
  logic [cars_pkg::ROW_BITS-1:0] row_cells;
  logic                         frame_last;

  modport source (output valid, output row_cells, output frame_last, input ready);
  modport sink (input valid, input row_cells, input frame_last, output ready);
endinterface

interface cars_out_if;
  logic                         valid;
  logic                         ready;
  logic [cars_pkg::ROW_BITS-1:0] next_cells;
  logic                         frame_done;

  modport source (output valid, output next_cells, output frame_done, input ready);
  modport sink (input valid, input next_cells, input frame_done, output ready);
endinterface

FILE: src/cars_lane.sv
// One cell of the automaton: neighbor wall count and the survive/birth rule.
module cars_lane (
  input  logic [7:0]            nbrs,
  input  logic                  self_wall,
  input  cars_pkg::rule_t       rule,
  output logic                  wall
);

  logic [cars_pkg::COUNT_BITS-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + cars_pkg::COUNT_BITS'(nbrs[i]);
    end
  end

  always_comb begin
    if (self_wall) begin
      wall = (count >= rule.starvation) && (count <= rule.overpopulation);
    end else begin
      wall = count > rule.birth;
    end
  end

endmodule

FILE: src/cars_row_eval.sv
// A row of cell lanes side by side, merged into one masked result row.
module cars_row_eval #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] up,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] down,
  input  logic [WIDTH-1:0] mask,
  input  cars_pkg::rule_t  rule,
  output logic [WIDTH-1:0] next
);

  // Cells outside the active width, and the columns beyond both edges, read as walls.
  logic [WIDTH+1:0] up_x;
  logic [WIDTH+1:0] mid_x;
  logic [WIDTH+1:0] down_x;
  logic [WIDTH-1:0] lane_wall;

  assign up_x   = {1'b1, up | ~mask, 1'b1};
  assign mid_x  = {1'b1, mid | ~mask, 1'b1};
  assign down_x = {1'b1, down | ~mask, 1'b1};

  for (genvar c = 0; c < WIDTH; c++) begin : g_lane
    cars_lane u_lane (
      .nbrs      ({up_x[c], up_x[c+1], up_x[c+2], mid_x[c], mid_x[c+2],
                   down_x[c], down_x[c+1], down_x[c+2]}),
      .self_wall (mid[c]),
      .rule      (rule),
      .wall      (lane_wall[c])
    );
  end

  assign next = lane_wall & mask;

endmodule

FILE: src/cars_out_buf.sv
// Two-entry result buffer that drives the output channel.
module cars_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cars_pkg::result_t   push_data,
  output logic                space,
  cars_out_if.source          out_ch
);

  cars_pkg::result_t mem [2];
  logic              head;
  logic              tail;
  logic [1:0]        count;
  logic              pop;

  assign pop   = out_ch.valid && out_ch.ready;
  assign space = count != 2'd2;

  assign out_ch.valid      = count != 2'd0;
  assign out_ch.next_cells = mem[head].next_cells;
  assign out_ch.frame_done = mem[head].frame_done;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/cave_automaton_row_step.sv
// Top level of the cave automaton row step: row store, lanes and result buffer.
// One row is taken per clock cycle while the two-entry result buffer has space
// and no flush is pending. A row's next generation is pushed into it in the same
// cycle that the row below it is taken; after the last row of a frame a flush
// evaluates the held row against a wall row below and holds off the input. All
// MAX_WIDTH cells are evaluated at once by one lane each from the stored row
// above, the held row and the incoming row. Configuration must be written over
// the APB port by the user while no frame is in flight; the block does not check.
module cave_automaton_row_step #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  cars_in_if.sink                          row_in,
  cars_out_if.source                       row_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cars_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [cars_pkg::DATA_BITS-1:0]   pwdata,
  output logic [cars_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);

  localparam int WB = cars_pkg::WIDTH_BITS;

  logic [WB-1:0]         row_width;
  cars_pkg::rule_t       rule;
  logic                  cfg_write;

  logic [WB-1:0]         width_act;
  logic [MAX_WIDTH-1:0]  mask;
  logic [MAX_WIDTH-1:0]  row_masked;

  logic [MAX_WIDTH-1:0]  row_above;
  logic [MAX_WIDTH-1:0]  row_middle;
  logic                  middle_valid;
  logic                  flush_pending;

  logic                  accept;
  logic                  flush;
  logic                  space;
  logic                  push;
  logic [MAX_WIDTH-1:0]  eval_down;
  logic [MAX_WIDTH-1:0]  eval_next;
  cars_pkg::result_t     push_data;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width           <= cars_pkg::ROW_WIDTH_RST;
      rule.starvation     <= cars_pkg::STARVATION_RST;
      rule.overpopulation <= cars_pkg::OVERPOPULATION_RST;
      rule.birth          <= cars_pkg::BIRTH_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        cars_pkg::REG_ROW_WIDTH:      row_width <= pwdata[WB-1:0];
        cars_pkg::REG_STARVATION:     rule.starvation <= pwdata[cars_pkg::LIMIT_BITS-1:0];
        cars_pkg::REG_OVERPOPULATION: rule.overpopulation <= pwdata[cars_pkg::LIMIT_BITS-1:0];
        cars_pkg::REG_BIRTH:          rule.birth <= pwdata[cars_pkg::LIMIT_BITS-1:0];
        default:                      row_width <= row_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cars_pkg::REG_ROW_WIDTH:      prdata = cars_pkg::DATA_BITS'(row_width);
      cars_pkg::REG_STARVATION:     prdata = cars_pkg::DATA_BITS'(rule.starvation);
      cars_pkg::REG_OVERPOPULATION: prdata = cars_pkg::DATA_BITS'(rule.overpopulation);
      cars_pkg::REG_BIRTH:          prdata = cars_pkg::DATA_BITS'(rule.birth);
      default:                      prdata = '0;
    endcase
  end

  // Active width and the mask of cells in use.
  assign width_act = (row_width > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : row_width;

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
    assign mask[c] = WB'(c) < width_act;
  end

  assign row_masked = row_in.row_cells[MAX_WIDTH-1:0] & mask;

  // Handshake and row store.
  assign row_in.ready = !flush_pending && space;
  assign accept       = row_in.valid && row_in.ready;
  assign flush        = flush_pending && space;
  assign push         = (accept && middle_valid) || flush;

  always_ff @(posedge clk) begin
    if (accept) begin
      row_middle <= row_masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above     <= '1;
      middle_valid  <= 1'b0;
      flush_pending <= 1'b0;
    end else if (flush) begin
      row_above     <= '1;
      middle_valid  <= 1'b0;
      flush_pending <= 1'b0;
    end else if (accept) begin
      if (middle_valid) begin
        row_above <= row_middle;
      end
      middle_valid  <= 1'b1;
      flush_pending <= row_in.frame_last;
    end
  end

  // During a flush the row below the held row is the bottom boundary.
  assign eval_down = flush_pending ? '1 : row_masked;

  cars_row_eval #(
    .WIDTH (MAX_WIDTH)
  ) u_row_eval (
    .up   (row_above),
    .mid  (row_middle),
    .down (eval_down),
    .mask (mask),
    .rule (rule),
    .next (eval_next)
  );

  assign push_data.next_cells = cars_pkg::ROW_BITS'(eval_next);
  assign push_data.frame_done = flush_pending;

  cars_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_ch    (row_out)
  );

endmodule

FILE: src/cars_check.sv
// Port-level checks of the cave automaton row step, bound to the top level.
`include "cave_automaton_row_step_assert.svh"

module cars_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [cars_pkg::ROW_BITS-1:0]  out_cells,
  input  logic                           out_done
);

  // A result that is not taken stays on the port unchanged.
  `CARS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cells) && $stable(out_done), "stalled result changed")

  // The flush of the last row blocks the input in the following cycle.
  `CARS_ASSERT(a_last_blocks, in_valid && in_ready && in_last |=> !in_ready, "input taken during flush")

  // Reset empties the result buffer.
  `CARS_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result pending after reset")

endmodule

bind cave_automaton_row_step cars_check u_cars_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (row_in.valid),
  .in_ready  (row_in.ready),
  .in_last   (row_in.frame_last),
  .out_valid (row_out.valid),
  .out_ready (row_out.ready),
  .out_cells (row_out.next_cells),
  .out_done  (row_out.frame_done)
);

FILE: tb/cars_row_checker.sv
`timescale 1ns / 100ps
// Checker for the cave automaton row step: predicts every result row and compares it.
module cars_row_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [cars_pkg::ROW_BITS-1:0]  in_cells,
  input  logic                           in_last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [cars_pkg::ROW_BITS-1:0]  out_cells,
  input  logic                           out_done,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [cars_pkg::ADDR_BITS-1:0] paddr,
  input  logic [cars_pkg::DATA_BITS-1:0] pwdata,
  output int                             failures,
  output int                             pending
);

  logic [cars_pkg::WIDTH_BITS-1:0] width_reg;
  cars_pkg::rule_t                 rules;
  logic [cars_pkg::ROW_BITS-1:0]   above_row;
  logic [cars_pkg::ROW_BITS-1:0]   held_row;
  logic                            held_valid;
  cars_pkg::result_t               expected_rows[$];
  int                              fail_count;

  function automatic int active_cells();
    int w;
    w = int'(width_reg);
    if (w > cars_pkg::ROW_BITS) w = cars_pkg::ROW_BITS;
    return w;
  endfunction

  function automatic logic [cars_pkg::ROW_BITS-1:0] width_mask(int w);
    return {cars_pkg::ROW_BITS{1'b1}} >> (cars_pkg::ROW_BITS - w);
  endfunction

  // Cells outside the active width, and the rows beyond the grid, read as wall.
  function automatic int wall_at(logic [cars_pkg::ROW_BITS-1:0] row, int c, int w);
    if (c < 0 || c >= w) return 1;
    return int'(row[c]);
  endfunction

  function automatic logic [cars_pkg::ROW_BITS-1:0] next_generation(
    logic [cars_pkg::ROW_BITS-1:0] up,
    logic [cars_pkg::ROW_BITS-1:0] mid,
    logic [cars_pkg::ROW_BITS-1:0] down);
    int                            w;
    int                            walls;
    logic [cars_pkg::ROW_BITS-1:0] gen;
    w = active_cells();
    gen = '0;
    for (int c = 0; c < w; c++) begin
      walls = 0;
      for (int d = -1; d <= 1; d++) begin
        walls += wall_at(up, c + d, w) + wall_at(down, c + d, w);
        if (d != 0) walls += wall_at(mid, c + d, w);
      end
      if (mid[c]) begin
        gen[c] = walls >= int'(rules.starvation) && walls <= int'(rules.overpopulation);
      end else begin
        gen[c] = walls > int'(rules.birth);
      end
    end
    return gen & width_mask(w);
  endfunction

  function automatic void take_row(logic [cars_pkg::ROW_BITS-1:0] cells, logic last);
    logic [cars_pkg::ROW_BITS-1:0] row;
    cars_pkg::result_t             res;
    row = cells & width_mask(active_cells());
    if (held_valid) begin
      res.next_cells = next_generation(above_row, held_row, row);
      res.frame_done = 1'b0;
      expected_rows.insert(expected_rows.size(), res);
      above_row = held_row;
    end
    held_row = row;
    held_valid = 1'b1;
    // The last row is evaluated at once against a wall row below the grid.
    if (last) begin
      res.next_cells = next_generation(above_row, held_row, '1);
      res.frame_done = 1'b1;
      expected_rows.insert(expected_rows.size(), res);
      above_row = '1;
      held_row = '0;
      held_valid = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    cars_pkg::result_t want;
    if (rst) begin
      width_reg = cars_pkg::ROW_WIDTH_RST;
      rules.starvation = cars_pkg::STARVATION_RST;
      rules.overpopulation = cars_pkg::OVERPOPULATION_RST;
      rules.birth = cars_pkg::BIRTH_RST;
      above_row = '1;
      held_row = '0;
      held_valid = 1'b0;
      expected_rows.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          fail_count++;
          $display("%0t: result row expected none, actual next_cells %h frame_done %b",
                   $time, out_cells, out_done);
        end else begin
          want = expected_rows.pop_front();
          if (out_cells !== want.next_cells) begin
            fail_count++;
            $display("%0t: next_cells expected %h actual %h",
                     $time, want.next_cells, out_cells);
          end
          if (out_done !== want.frame_done) begin
            fail_count++;
            $display("%0t: frame_done expected %b actual %b",
                     $time, want.frame_done, out_done);
          end
        end
      end
      if (in_valid && in_ready) take_row(in_cells, in_last);
      if (psel && penable && pwrite && pready) begin
        case (paddr[cars_pkg::ADDR_BITS-1:2])
          cars_pkg::REG_ROW_WIDTH:      width_reg = pwdata[cars_pkg::WIDTH_BITS-1:0];
          cars_pkg::REG_STARVATION:     rules.starvation = pwdata[cars_pkg::LIMIT_BITS-1:0];
          cars_pkg::REG_OVERPOPULATION: rules.overpopulation = pwdata[cars_pkg::LIMIT_BITS-1:0];
          cars_pkg::REG_BIRTH:          rules.birth = pwdata[cars_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end
    end
    failures <= fail_count;
    pending <= expected_rows.size();
  end

endmodule

FILE: tb/tb_cave_automaton_row_step.sv
`timescale 1ns / 100ps
// Top of the cave automaton row step testbench: clock, reset, stimulus and verdict.
module tb_cave_automaton_row_step;

  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASES         = 12;
  localparam int ROWS_PER_PHASE = 140;
  localparam int FIXED_PHASES   = 7;
  localparam int NO_GAP_PHASE   = 3;

  // Settings of the first phases: width above the maximum, zero width, a single
  // cell, limits outside the span of counts and limits that cross over.
  localparam int FIXED_WIDTH [FIXED_PHASES] = '{127, 0, 1, 64, 65, 3, 2};
  localparam int FIXED_STARVE[FIXED_PHASES] = '{0, 3, 15, 4, 9, 2, 0};
  localparam int FIXED_OVER  [FIXED_PHASES] = '{15, 10, 15, 8, 2, 7, 0};
  localparam int FIXED_BIRTH [FIXED_PHASES] = '{0, 4, 15, 4, 9, 3, 8};

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cars_pkg::ADDR_BITS-1:0] paddr;
  logic [cars_pkg::DATA_BITS-1:0] pwdata;
  logic [cars_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;
  logic                           rx_gaps;
  logic                           hold_toggle;
  bit                             tx_gaps;
  int                             failures;
  int                             pending;
  int                             quiet_cycles;

  cars_in_if  row_in ();
  cars_out_if row_out ();

  cave_automaton_row_step i_dut (
    .clk     (clk),
    .rst     (rst),
    .row_in  (row_in),
    .row_out (row_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cars_row_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_in.valid),
    .in_ready  (row_in.ready),
    .in_cells  (row_in.row_cells),
    .in_last   (row_in.frame_last),
    .out_valid (row_out.valid),
    .out_ready (row_out.ready),
    .out_cells (row_out.next_cells),
    .out_done  (row_out.frame_done),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off each time hold_toggle flips.
  initial begin
    logic seen_toggle;
    int   hold_left;
    seen_toggle = 1'b0;
    hold_left = 0;
    row_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        row_out.ready <= 1'b0;
      end else begin
        row_out.ready <= !rx_gaps || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (row_in.valid && row_in.ready) || (row_out.valid && row_out.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("cave_automaton_row_step verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= cars_pkg::DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rules(input int width, input int starve, input int over,
                           input int birth);
    write_reg(cars_pkg::REG_ROW_WIDTH, width);
    write_reg(cars_pkg::REG_STARVATION, starve);
    write_reg(cars_pkg::REG_OVERPOPULATION, over);
    write_reg(cars_pkg::REG_BIRTH, birth);
  endtask

  task automatic send_row(input logic [cars_pkg::ROW_BITS-1:0] cells, input logic last);
    while (tx_gaps && $urandom_range(0, 99) < 10) begin
      row_in.valid <= 1'b0;
      @(posedge clk);
    end
    row_in.valid <= 1'b1;
    row_in.row_cells <= cells;
    row_in.frame_last <= last;
    do @(posedge clk); while (!row_in.ready);
  endtask

  // Stops offering rows until every expected result row has been transferred.
  // The pending count is registered, so the first edge is always waited out.
  task automatic drain();
    row_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [cars_pkg::ROW_BITS-1:0] random_row();
    logic [cars_pkg::ROW_BITS-1:0] a;
    logic [cars_pkg::ROW_BITS-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return a & b;
      1:       return a | b;
      2:       return a & b & {$urandom, $urandom};
      3:       return $urandom_range(0, 1) ? '1 : '0;
      default: return a;
    endcase
  endfunction

  task automatic send_frame(input int rows, input int pause_at);
    for (int r = 0; r < rows; r++) begin
      if (r == pause_at) drain();
      send_row(random_row(), r == rows - 1);
    end
  endtask

  initial begin
    int rows_sent;
    int rows;
    int pause_at;
    int width;
    rst = 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    row_in.valid <= 1'b0;
    row_in.row_cells <= '0;
    row_in.frame_last <= 1'b0;
    rx_gaps <= 1'b1;
    hold_toggle <= 1'b0;
    tx_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset settings: single-row frames of solid
    // wall and solid floor, then alternating patterns and edge cells.
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row({32{2'b01}}, 1'b0);
    send_row({32{2'b10}}, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h0000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b1);
    send_frame(4, -1);
    send_frame(2, 1);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < FIXED_PHASES) begin
        set_rules(FIXED_WIDTH[phase], FIXED_STARVE[phase], FIXED_OVER[phase],
                  FIXED_BIRTH[phase]);
      end else begin
        case ($urandom_range(0, 3))
          0:       width = $urandom_range(0, 127);
          1:       width = $urandom_range(1, 8);
          2:       width = $urandom_range(60, 66);
          default: width = $urandom_range(3, 64);
        endcase
        if ($urandom_range(0, 1)) begin
          set_rules(width, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15));
        end else begin
          set_rules(width, $urandom_range(2, 5), $urandom_range(6, 10),
                    $urandom_range(3, 5));
        end
      end
      tx_gaps = (phase != NO_GAP_PHASE);
      rx_gaps <= (phase != NO_GAP_PHASE);
      rows_sent = 0;
      while (rows_sent < ROWS_PER_PHASE) begin
        rows = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
        // Midway through each phase the sender waits for every result row once.
        pause_at = (rows_sent < ROWS_PER_PHASE / 2 &&
                    rows_sent + rows >= ROWS_PER_PHASE / 2) ? rows / 2 : -1;
        // A long hold-off on the result side fills the block while rows keep coming.
        if ((phase == 5 || phase == 9) && rows_sent == 0) begin
          hold_toggle <= ~hold_toggle;
          rows = 24;
        end
        send_frame(rows, pause_at);
        rows_sent += rows;
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("cave_automaton_row_step verification clean");
    end else begin
      $display("cave_automaton_row_step verification failed");
    end
    $finish;
  end

endmodule
